// ===== rtl/core/bra_pkg.sv =====
// Shared constants, codes and item types for the bitmap run allocator.
`default_nettype none

package bra_pkg;

	// Default geometry; WORD_BITS and BITMAP_BITS / WORD_BITS are powers of two
	localparam int BITMAP_BITS_DEF = 8192;
	localparam int WORD_BITS_DEF   = 32;

	// Fixed field widths
	localparam int KIND_W   = 1;
	localparam int IDX_W    = 8;
	localparam int DATA_W   = 32;
	localparam int REQ_W    = 14;
	localparam int BASE_W   = 32;
	localparam int STATUS_W = 2;

	// Stream payload widths, padded to whole bytes
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 48;

	// Input kinds
	localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_PARTIAL = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_LOADED  = 2'd3;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS     = 1'b1;
	localparam logic [REQ_W-1:0]     BLOCKS_RESET   = 14'd8192;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  word_index;
		logic [DATA_W-1:0] word_data;
		logic [REQ_W-1:0]  request_count;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BASE_W-1:0]   start_block;
		logic [REQ_W-1:0]    granted_count;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bra_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bra_ctrl.sv =====
// Allocation sequencer: bitmap RAM, word scan and read-modify-write run setting.
`default_nettype none

module bra_ctrl #(
	parameter int BITMAP_BITS = bra_pkg::BITMAP_BITS_DEF,
	parameter int WORD_BITS   = bra_pkg::WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	input  wire bra_pkg::item_t              item,
	output logic                             idle,
	output logic                             res_valid,
	input  wire logic                        res_taken,
	output bra_pkg::result_t                 res,
	input  wire logic [bra_pkg::BASE_W-1:0]  group_base_block,
	input  wire logic [bra_pkg::REQ_W-1:0]   blocks_in_group
);

	localparam int MAP_WORDS = BITMAP_BITS / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int POS_W     = $clog2(WORD_BITS);
	localparam int TZ_W      = POS_W + 1;
	localparam int CNT_W     = ($clog2(BITMAP_BITS + 1) > bra_pkg::REQ_W) ?
	                           $clog2(BITMAP_BITS + 1) : bra_pkg::REQ_W;
	localparam int REQ_W     = bra_pkg::REQ_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [WORD_BITS-1:0] ONES  = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS:0]   ONES1 = {(WORD_BITS + 1){1'b1}};

	// Lowest set bit of a word
	function automatic logic [POS_W-1:0] low_set(input logic [WORD_BITS-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) p = POS_W'(i);
		end
		return p;
	endfunction

	// Lowest set bit of a word with a sentinel on top
	function automatic logic [TZ_W-1:0] low_set1(input logic [WORD_BITS:0] v);
		logic [TZ_W-1:0] p;
		p = '0;
		for (int i = WORD_BITS; i >= 0; i--) begin
			if (v[i]) p = TZ_W'(i);
		end
		return p;
	endfunction

	logic [1:0]              state_q;
	logic                    run_q;
	logic [AW-1:0]           w_q;
	logic [AW-1:0]           last_word_q;
	logic [WORD_BITS-1:0]    tail_q;
	logic [WORD_BITS-1:0]    raw_q;
	logic [WORD_BITS-1:0]    used_q;
	logic [POS_W-1:0]        pos_q;
	logic [AW+POS_W-1:0]     first_q;
	logic [REQ_W-1:0]        want_q;
	logic [REQ_W-1:0]        num_q;
	logic [bra_pkg::STATUS_W-1:0] st_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [WORD_BITS-1:0]    ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [WORD_BITS-1:0]    ram_rdata;

	logic [CNT_W-1:0]        big_ext;
	logic [CNT_W-1:0]        limit;
	logic [CNT_W-1:0]        lm1;
	logic [WORD_BITS:0]      tail_wide;
	logic                    is_alloc;
	logic                    load_hit;

	logic [WORD_BITS-1:0]    masked;
	logic                    any_free;
	logic [POS_W-1:0]        free_pos;
	logic                    scan_next;

	logic [WORD_BITS-1:0]    vec;
	logic [TZ_W-1:0]         endp;
	logic [TZ_W-1:0]         tz;
	logic [REQ_W-1:0]        rem;
	logic [TZ_W-1:0]         take;
	logic [TZ_W-1:0]         upto;
	logic [WORD_BITS-1:0]    setmask;
	logic [REQ_W-1:0]        num_n;
	logic                    cont;

	bra_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Accept-time decode: clamp the group size, prepare the last-word mask, decode the kind and check the load index
	always_comb begin
		big_ext   = CNT_W'(blocks_in_group);
		limit     = (big_ext > CNT_W'(BITMAP_BITS)) ? CNT_W'(BITMAP_BITS) : big_ext;
		lm1       = limit - CNT_W'(1);
		tail_wide = ONES1 << (TZ_W'(lm1[POS_W-1:0]) + TZ_W'(1));
		is_alloc  = (item.kind == bra_pkg::KIND_ALLOC);
		load_hit  = (32'(item.word_index) < MAP_WORDS);
	end

	// Scan: mark bits beyond the group end as used, look for a clear bit
	always_comb begin
		masked    = ram_rdata | ((w_q == last_word_q) ? tail_q : '0);
		any_free  = |(~masked);
		free_pos  = low_set(~masked);
		scan_next = !run_q && !any_free && (w_q != last_word_q);
	end

	// Run: set the clear bits from pos_q up to the next used bit, capped by what remains
	always_comb begin
		vec     = used_q & (ONES << pos_q);
		endp    = low_set1({1'b1, vec});
		tz      = endp - {1'b0, pos_q};
		rem     = want_q - num_q;
		take    = (REQ_W'(tz) < rem) ? tz : TZ_W'(rem);
		upto    = {1'b0, pos_q} + take;
		setmask = WORD_BITS'((ONES1 << pos_q) & ~(ONES1 << upto));
		num_n   = num_q + REQ_W'(take);
		cont    = (upto == TZ_W'(WORD_BITS)) && (num_n != want_q) &&
		          (w_q != last_word_q);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = raw_q | setmask;
		ram_re    = 1'b0;
		ram_raddr = w_q + AW'(1);
		case (state_q)
			S_IDLE: begin
				if (item_valid && !is_alloc && load_hit) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(item.word_index);
					ram_wdata = WORD_BITS'(item.word_data);
				end
				if (item_valid && is_alloc && (limit != '0)) begin
					ram_re    = 1'b1;
					ram_raddr = '0;
				end
			end
			S_EVAL: begin
				ram_re = scan_next;
			end
			S_RUN: begin
				ram_we = 1'b1;
				ram_re = cont;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_q       <= 1'b0;
			w_q         <= '0;
			last_word_q <= '0;
			tail_q      <= '0;
			raw_q       <= '0;
			used_q      <= '0;
			pos_q       <= '0;
			first_q     <= '0;
			want_q      <= '0;
			num_q       <= '0;
			st_q        <= bra_pkg::STATUS_LOADED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						num_q <= '0;
						if (!is_alloc) begin
							st_q    <= bra_pkg::STATUS_LOADED;
							state_q <= S_DONE;
						end else if (limit == '0) begin
							st_q    <= bra_pkg::STATUS_NOSPACE;
							state_q <= S_DONE;
						end else begin
							run_q       <= 1'b0;
							w_q         <= '0;
							last_word_q <= AW'(lm1 >> POS_W);
							tail_q      <= tail_wide[WORD_BITS-1:0];
							want_q      <= item.request_count;
							state_q     <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					raw_q  <= ram_rdata;
					used_q <= masked;
					if (run_q) begin
						pos_q   <= '0;
						state_q <= S_RUN;
					end else if (any_free) begin
						run_q   <= 1'b1;
						pos_q   <= free_pos;
						first_q <= {w_q, free_pos};
						state_q <= S_RUN;
					end else if (scan_next) begin
						w_q <= w_q + AW'(1);
					end else begin
						st_q    <= bra_pkg::STATUS_NOSPACE;
						state_q <= S_DONE;
					end
				end
				S_RUN: begin
					num_q <= num_n;
					if (cont) begin
						w_q     <= w_q + AW'(1);
						state_q <= S_EVAL;
					end else begin
						st_q    <= (num_n < want_q) ? bra_pkg::STATUS_PARTIAL :
						                              bra_pkg::STATUS_DONE;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_taken) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status        = st_q;
		res.granted_count = num_q;
		if ((st_q == bra_pkg::STATUS_DONE) || (st_q == bra_pkg::STATUS_PARTIAL)) begin
			res.start_block = group_base_block + bra_pkg::BASE_W'(first_q);
		end else begin
			res.start_block = '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_run_allocator_top.sv =====
// Top level of the bitmap run allocator: configuration, stream ports, result register.
//
//  Channel  | Dir | Handshake            | Carries
//  ---------+-----+----------------------+-----------------------------------------
//  s_*      | in  | s_tvalid / s_tready  | load or allocate item (kind in s_tuser)
//  m_*      | out | m_tvalid / m_tready  | result (status in m_tuser)
//  cfg_*    | in  | cfg_valid / cfg_ready| register write: index and data
//
// One item is worked at a time. An allocation scans the bitmap RAM one word
// per cycle until a clear bit turns up, then sets the run word by word: each
// word is read, then modified and written back over the RAM's registered
// read port. Reset clears control and restores the register defaults; the
// bitmap itself holds garbage until loaded. A stalled m_tready holds the
// result register, and a new item is taken as soon as the sequencer is idle.
`default_nettype none

module bitmap_run_allocator_top #(
	parameter int BITMAP_BITS = bra_pkg::BITMAP_BITS_DEF,
	parameter int WORD_BITS   = bra_pkg::WORD_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input items
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [7:0] word_index, [39:8] word_data, [53:40] request_count, [55:54] zero
	input  wire logic [bra_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] kind
	input  wire logic [bra_pkg::KIND_W-1:0]     s_tuser,
	// Results
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [31:0] start_block, [45:32] granted_count, [47:46] zero
	output logic      [bra_pkg::M_TDATA_W-1:0]  m_tdata,
	// [1:0] status
	output logic      [bra_pkg::STATUS_W-1:0]   m_tuser,
	// Configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bra_pkg::BASE_W-1:0]     cfg_data
);

	logic [bra_pkg::BASE_W-1:0]   group_base_q;
	logic [bra_pkg::REQ_W-1:0]    blocks_q;

	logic                         out_valid_q;
	bra_pkg::result_t             out_q;

	bra_pkg::item_t               item;
	bra_pkg::result_t             res;
	logic                         idle;
	logic                         res_valid;
	logic                         res_taken;
	logic                         in_xfer;

	// Configuration is always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_base_q <= '0;
			blocks_q     <= bra_pkg::BLOCKS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				bra_pkg::CFG_GROUP_BASE: group_base_q <= cfg_data;
				bra_pkg::CFG_BLOCKS:     blocks_q     <= cfg_data[bra_pkg::REQ_W-1:0];
				default: begin
					blocks_q <= blocks_q;
				end
			endcase
		end
	end

	// Unpack the input transfer
	assign item.kind          = s_tuser;
	assign item.word_index    = s_tdata[7:0];
	assign item.word_data     = s_tdata[39:8];
	assign item.request_count = s_tdata[53:40];

	assign s_tready = idle;
	assign in_xfer  = s_tvalid && idle;

	bra_ctrl #(
		.BITMAP_BITS (BITMAP_BITS),
		.WORD_BITS   (WORD_BITS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (in_xfer),
		.item             (item),
		.idle             (idle),
		.res_valid        (res_valid),
		.res_taken        (res_taken),
		.res              (res),
		.group_base_block (group_base_q),
		.blocks_in_group  (blocks_q)
	);

	// Advance a finished result into the output register when it is free
	assign res_taken = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_taken) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {2'b00, out_q.granted_count, out_q.start_block};

endmodule

`default_nettype wire
